[sv/tournament_branch_predictor_macros.svh]
// Assertion macros shared by the tournament branch predictor RTL.
// Bodies vanish when SYNTHESIS is defined; no other dependencies.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tbp assertion failed");
// next-cycle implication
`define TBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tbp assertion failed");
`else
`define TBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/tbp_pkg.sv]
// Shared types, codes and helpers for the tournament branch predictor.
// No dependencies.
package tbp_pkg;

	// table entry: written flag plus 2-bit saturating counter
	typedef struct packed {
		logic       written;
		logic [1:0] ctr;
	} entry_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MODE          = 3'd0,
		CFG_BIMODAL_BITS  = 3'd1,
		CFG_HISTORY_BITS  = 3'd2,
		CFG_COUNTER_START = 3'd3,
		CFG_CHOOSER_START = 3'd4
	} cfg_reg_t;

	localparam logic [1:0] MODE_BIMODAL    = 2'd0;
	localparam logic [1:0] MODE_GSHARE     = 2'd1;
	localparam logic [1:0] MODE_TOURNAMENT = 2'd2;

	localparam logic [1:0] RST_MODE          = MODE_TOURNAMENT;
	localparam logic [3:0] RST_BIMODAL_BITS  = 4'd11;
	localparam logic [3:0] RST_HISTORY_BITS  = 4'd11;
	localparam logic [1:0] RST_COUNTER_START = 2'd3;
	localparam logic [1:0] RST_CHOOSER_START = 2'd0;

	function automatic logic [1:0] sat_step(input logic [1:0] c, input logic up);
		logic [1:0] r;
		r = c;
		if (up) begin
			if (c != 2'd3) r = c + 2'd1;
		end else begin
			if (c != 2'd0) r = c - 2'd1;
		end
		return r;
	endfunction

endpackage

[sv/tournament_branch_predictor.sv]
// Tournament branch predictor top level: bimodal, gshare and chooser tables.
// Depends on tbp_pkg, tbp_table, tbp_clear and the assertion macro header.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | branch_address, actual_taken
//  out     | output    | out_valid / out_stall| predicted_taken, prediction_correct,
//          |           |                      | hit_count, branch_count
//  cfg     | input     | cfg_write_en         | cfg_index, cfg_data
//
// One item per cycle when not stalled; items pass stage 1, then the result register.
// Table read on accept, update and write-back as stage 1 advances; last write forwarded.
// After reset a clearing sweep over all 2**INDEX_BITS rows holds in_stall high.
// out_stall holds a valid result and, if stage 1 is full, stalls input in the same cycle.
`include "tournament_branch_predictor_macros.svh"

module tournament_branch_predictor #(
	parameter int INDEX_BITS = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] branch_address,
	input  logic        actual_taken,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        predicted_taken,
	output logic        prediction_correct,
	output logic [31:0] hit_count,
	output logic [31:0] branch_count,
	input  logic        cfg_write_en,
	input  logic [tbp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tbp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tbp_pkg::*;

	// configuration registers
	logic [1:0] mode_q;
	logic [3:0] bbits_q;
	logic [3:0] hbits_q;
	logic [1:0] cstart_q;
	logic [1:0] chstart_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= RST_MODE;
			bbits_q   <= RST_BIMODAL_BITS;
			hbits_q   <= RST_HISTORY_BITS;
			cstart_q  <= RST_COUNTER_START;
			chstart_q <= RST_CHOOSER_START;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_MODE:          mode_q    <= cfg_data[1:0];
				CFG_BIMODAL_BITS:  bbits_q   <= cfg_data;
				CFG_HISTORY_BITS:  hbits_q   <= cfg_data;
				CFG_COUNTER_START: cstart_q  <= cfg_data[1:0];
				CFG_CHOOSER_START: chstart_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// masks: bit j kept when j < configured length (over-long values saturate)
	logic [INDEX_BITS-1:0] bmask;
	logic [INDEX_BITS-1:0] hmask;

	always_comb begin
		for (int j = 0; j < INDEX_BITS; j++) begin
			bmask[j] = (j < int'(bbits_q));
			hmask[j] = (j < int'(hbits_q));
		end
	end

	// clearing sweep
	logic                  clr_busy;
	logic [INDEX_BITS-1:0] clr_addr;

	tbp_clear #(.INDEX_BITS(INDEX_BITS)) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

	// handshake
	logic in_acc;
	logic s1_adv;
	logic valid_s1;
	logic out_valid_q;

	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clr_busy || (valid_s1 && !s1_adv);
	assign in_acc   = in_valid && !in_stall;

	// stage 0: index computation, history update
	logic [INDEX_BITS-1:0] hist_q;
	logic [INDEX_BITS-1:0] addr_lo;
	logic [INDEX_BITS-1:0] bi;
	logic [INDEX_BITS-1:0] gi;

	assign addr_lo = branch_address[INDEX_BITS-1:0];
	assign bi      = addr_lo & bmask;
	assign gi      = addr_lo ^ hist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (in_acc) begin
			hist_q <= {hist_q[INDEX_BITS-2:0], actual_taken} & hmask;
		end
	end

	logic                  taken_s1;
	logic [INDEX_BITS-1:0] bi_s1;
	logic [INDEX_BITS-1:0] gi_s1;
	logic [INDEX_BITS-1:0] ci_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			taken_s1 <= actual_taken;
			bi_s1    <= bi;
			gi_s1    <= gi;
			ci_s1    <= addr_lo;
		end
	end

	// tables
	entry_t b_rd, g_rd, c_rd;
	entry_t b_wr, g_wr, c_wr;
	logic   pw_en, cw_en;
	logic [INDEX_BITS-1:0] bw_addr, gw_addr, cw_addr;

	tbp_table #(.INDEX_BITS(INDEX_BITS)) u_bimodal (
		.clk(clk), .arst_n(arst_n),
		.rd_en(in_acc), .rd_addr(bi),
		.wr_en(pw_en), .wr_addr(bw_addr), .wr_data(b_wr),
		.rd_data(b_rd)
	);

	tbp_table #(.INDEX_BITS(INDEX_BITS)) u_gshare (
		.clk(clk), .arst_n(arst_n),
		.rd_en(in_acc), .rd_addr(gi),
		.wr_en(pw_en), .wr_addr(gw_addr), .wr_data(g_wr),
		.rd_data(g_rd)
	);

	tbp_table #(.INDEX_BITS(INDEX_BITS)) u_chooser (
		.clk(clk), .arst_n(arst_n),
		.rd_en(in_acc), .rd_addr(addr_lo),
		.wr_en(cw_en), .wr_addr(cw_addr), .wr_data(c_wr),
		.rd_data(c_rd)
	);

	// stage 1: predict and train
	logic [1:0] b_ctr, g_ctr, c_ctr, c_new;
	logic       bpred, gpred, pred, ok;
	logic       tourn;

	assign tourn = mode_q[1];
	assign b_ctr = b_rd.written ? b_rd.ctr : cstart_q;
	assign g_ctr = g_rd.written ? g_rd.ctr : cstart_q;
	assign c_ctr = c_rd.written ? c_rd.ctr : chstart_q;
	assign bpred = b_ctr[1];
	assign gpred = g_ctr[1];
	assign ok    = (pred == taken_s1);

	always_comb begin
		case (mode_q)
			MODE_BIMODAL: pred = bpred;
			MODE_GSHARE:  pred = gpred;
			default:      pred = c_ctr[1] ? bpred : gpred;
		endcase
	end

	// chooser moves only when exactly one component was right
	always_comb begin
		c_new = c_ctr;
		if (bpred != gpred) begin
			c_new = sat_step(c_ctr, bpred == taken_s1);
		end
	end

	assign pw_en   = clr_busy || s1_adv;
	assign cw_en   = clr_busy || (s1_adv && tourn);
	assign bw_addr = clr_busy ? clr_addr : bi_s1;
	assign gw_addr = clr_busy ? clr_addr : gi_s1;
	assign cw_addr = clr_busy ? clr_addr : ci_s1;

	always_comb begin
		if (clr_busy) begin
			b_wr = '{written: 1'b0, ctr: 2'd0};
			g_wr = '{written: 1'b0, ctr: 2'd0};
			c_wr = '{written: 1'b0, ctr: 2'd0};
		end else begin
			b_wr = '{written: 1'b1, ctr: sat_step(b_ctr, taken_s1)};
			g_wr = '{written: 1'b1, ctr: sat_step(g_ctr, taken_s1)};
			c_wr = '{written: 1'b1, ctr: c_new};
		end
	end

	// result register and running counts
	logic        pred_q, ok_q;
	logic [31:0] hits_q, branches_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			branches_q  <= '0;
		end else begin
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				hits_q      <= hits_q + 32'(ok);
				branches_q  <= branches_q + 32'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pred_q <= pred;
			ok_q   <= ok;
		end
	end

	assign out_valid          = out_valid_q;
	assign predicted_taken    = pred_q;
	assign prediction_correct = ok_q;
	assign hit_count          = hits_q;
	assign branch_count       = branches_q;

	`TBP_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, clr_busy, in_stall)
	`TBP_ASSERT_NXT(a_branch_count_step, clk, arst_n, s1_adv, branches_q == $past(branches_q) + 32'd1)
	`TBP_ASSERT_NXT(a_hits_hold, clk, arst_n, !s1_adv, $stable(hits_q) && $stable(branches_q))
	`TBP_ASSERT_NXT(a_hit_flag, clk, arst_n, s1_adv, hits_q == $past(hits_q) + 32'(ok_q))

endmodule

[sv/tbp_table.sv]
// One counter table: synchronous RAM with registered read and write forwarding.
// Depends on tbp_pkg (entry_t).
module tbp_table #(
	parameter int INDEX_BITS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [INDEX_BITS-1:0] rd_addr,
	input  logic                  wr_en,
	input  logic [INDEX_BITS-1:0] wr_addr,
	input  tbp_pkg::entry_t       wr_data,
	output tbp_pkg::entry_t       rd_data
);
	import tbp_pkg::*;

	localparam int DEPTH = 1 << INDEX_BITS;

	entry_t                mem [DEPTH];
	entry_t                rdata_q;
	logic [INDEX_BITS-1:0] raddr_q;
	logic                  fwd_valid_q;
	logic [INDEX_BITS-1:0] fwd_addr_q;
	entry_t                fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			raddr_q <= rd_addr;
		end
	end

	// last write; covers a read that raced the write on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data = (fwd_valid_q && fwd_addr_q == raddr_q) ? fwd_data_q : rdata_q;

endmodule

[sv/tbp_clear.sv]
// Post-reset clearing sweep: one table row per cycle.
// No dependencies.
module tbp_clear #(
	parameter int INDEX_BITS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	output logic                  busy,
	output logic [INDEX_BITS-1:0] addr
);
	logic                  busy_q;
	logic [INDEX_BITS-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + {{(INDEX_BITS-1){1'b0}}, 1'b1};
			if (cnt_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign addr = cnt_q;

endmodule
